// File: src/hpmc_pkg.sv
// Package for the Heston path stepper: payload and register types,
// datapath operation codes, controller/datapath command types, helpers.
// No dependencies.
package hpmc_pkg;

   // default binary point position of the state and register Q formats
   localparam int FRAC_BITS_DEF = 24;

   // width of the wide internal arithmetic (one full 33x33 signed product)
   localparam int WIDE = 66;

   // configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // register indexes
   localparam logic [2:0] REG_KAPPA_DT        = 3'd0;
   localparam logic [2:0] REG_LONG_VAR        = 3'd1;
   localparam logic [2:0] REG_VOLVOL_RHO_SDT  = 3'd2;
   localparam logic [2:0] REG_VOLVOL_COMP_SDT = 3'd3;
   localparam logic [2:0] REG_ROOT_DT         = 3'd4;
   localparam logic [2:0] REG_RATE_DT         = 3'd5;
   localparam logic [2:0] REG_STRIKE_RATIO    = 3'd6;
   localparam logic [2:0] REG_START_VAR       = 3'd7;

   // strike ratio reset: one in Q7.24
   localparam logic [30:0] STRIKE_RESET = 31'd16777216;

   // number of datapath steps in one time step
   localparam int NUM_STEPS = 15;
   localparam int STEP_W    = 4;

   // saturation bounds in the wide format
   localparam logic signed [WIDE-1:0] SAT_HI = {{(WIDE-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [WIDE-1:0] SAT_LO = {{(WIDE-31){1'b1}}, {31{1'b0}}};

   typedef struct packed {
      logic signed [15:0] normal_a;
      logic signed [15:0] normal_b;
      logic               path_end;
      logic               batch_end;
   } req_type;

   typedef struct packed {
      logic [30:0] path_payoff;
      logic [47:0] payoff_total;
      logic [23:0] paths_done;
      logic        batch_last;
   } rsp_type;

   typedef struct packed {
      logic [30:0]        kappa_dt;
      logic [30:0]        long_var;
      logic signed [31:0] volvol_rho_sdt;
      logic [30:0]        volvol_comp_sdt;
      logic [30:0]        root_dt;
      logic signed [31:0] rate_dt;
      logic [30:0]        strike_ratio;
      logic [30:0]        start_var;
   } cfg_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_DZ,      // dz = root_dt * a
      OP_WA,      // first half of the variance noise
      OP_WB,      // second half of the variance noise
      OP_SQRT,    // root of the selected variance
      OP_NOISE,   // sqrt(v) * w
      OP_KAP,     // mean reversion and variance update
      OP_D,       // spot increment factor
      OP_S        // spot update
   } op_type;

   typedef struct packed {
      op_type op;
      logic   twin;
   } step_type;

   // controller to datapath
   typedef struct packed {
      logic   take;     // latch the input transaction
      logic   load;     // reload the path state
      logic   mul;      // register the product
      logic   wb;       // write back the product
      logic   sq_go;    // start the square root
      logic   sq_wb;    // write back the root
      logic   pay;      // build the result
      op_type op;
      logic   twin;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pend;
      logic sq_done;
      logic out_busy;
   } sts_type;

   // step sequence of one time step
   function automatic step_type step_op(input logic [STEP_W-1:0] step);
      step_type          r;
      logic [STEP_W-1:0] k;
      r.twin = 1'b0;
      r.op   = OP_DZ;
      k      = '0;
      if (step < STEP_W'(3)) begin
         case (step)
            STEP_W'(0): r.op = OP_DZ;
            STEP_W'(1): r.op = OP_WA;
            default:    r.op = OP_WB;
         endcase
      end else begin
         k = step - STEP_W'(3);
         if (k >= STEP_W'(6)) begin
            r.twin = 1'b1;
            k      = k - STEP_W'(6);
         end
         case (k)
            STEP_W'(0): r.op = OP_SQRT;
            STEP_W'(1): r.op = OP_NOISE;
            STEP_W'(2): r.op = OP_KAP;
            STEP_W'(3): r.op = OP_SQRT;
            STEP_W'(4): r.op = OP_D;
            default:    r.op = OP_S;
         endcase
      end
      return r;
   endfunction

   // clamp to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[31:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[31:0];
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// File: src/hpmc_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nothing; used by the datapath.
module hpmc_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);

   logic [63:0] rad_ff, rad_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] rem_t;
   logic [33:0] trial;

   // one restoring digit step
   always_comb begin
      rem_t   = {rem_ff[31:0], rad_ff[63:62]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = 33'(rem_t - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_t[32:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// File: src/hpmc_csr.sv
// APB-style configuration registers of the Heston path stepper.
// Depends on hpmc_pkg.
module hpmc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [hpmc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [hpmc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [hpmc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output hpmc_pkg::cfg_type          cfg
);

   hpmc_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        idx;
   logic              wr;

   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            hpmc_pkg::REG_KAPPA_DT:        cfg_in.kappa_dt        = csr_pwdata[30:0];
            hpmc_pkg::REG_LONG_VAR:        cfg_in.long_var        = csr_pwdata[30:0];
            hpmc_pkg::REG_VOLVOL_RHO_SDT:  cfg_in.volvol_rho_sdt  = csr_pwdata;
            hpmc_pkg::REG_VOLVOL_COMP_SDT: cfg_in.volvol_comp_sdt = csr_pwdata[30:0];
            hpmc_pkg::REG_ROOT_DT:         cfg_in.root_dt         = csr_pwdata[30:0];
            hpmc_pkg::REG_RATE_DT:         cfg_in.rate_dt         = csr_pwdata;
            hpmc_pkg::REG_STRIKE_RATIO:    cfg_in.strike_ratio    = csr_pwdata[30:0];
            default:                       cfg_in.start_var       = csr_pwdata[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{strike_ratio: hpmc_pkg::STRIKE_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (idx)
         hpmc_pkg::REG_KAPPA_DT:        csr_prdata = {1'b0, cfg_ff.kappa_dt};
         hpmc_pkg::REG_LONG_VAR:        csr_prdata = {1'b0, cfg_ff.long_var};
         hpmc_pkg::REG_VOLVOL_RHO_SDT:  csr_prdata = cfg_ff.volvol_rho_sdt;
         hpmc_pkg::REG_VOLVOL_COMP_SDT: csr_prdata = {1'b0, cfg_ff.volvol_comp_sdt};
         hpmc_pkg::REG_ROOT_DT:         csr_prdata = {1'b0, cfg_ff.root_dt};
         hpmc_pkg::REG_RATE_DT:         csr_prdata = cfg_ff.rate_dt;
         hpmc_pkg::REG_STRIKE_RATIO:    csr_prdata = {1'b0, cfg_ff.strike_ratio};
         default:                       csr_prdata = {1'b0, cfg_ff.start_var};
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// File: src/hpmc_dp.sv
// Datapath of the Heston path stepper: path state, one shared multiplier,
// the square root unit, payoff accumulation and the result register.
// Depends on hpmc_pkg and hpmc_sqrt.
module hpmc_dp #(
   parameter int FRAC_BITS = hpmc_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  hpmc_pkg::cfg_type cfg,
   input  hpmc_pkg::cmd_type cmd,
   output hpmc_pkg::sts_type sts,
   input  hpmc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hpmc_pkg::rsp_type rsp_data
);

   localparam int W = hpmc_pkg::WIDE;
   localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

   hpmc_pkg::req_type  req_ff, req_in;
   logic [30:0]        vm_ff, vm_in, vt_ff, vt_in;
   logic signed [31:0] sm_ff, sm_in, st_ff, st_in;
   logic signed [31:0] dz_ff, dz_in, w_ff, w_in, f_ff, f_in;
   logic signed [35:0] tmp_ff, tmp_in;
   logic signed [49:0] noise_ff, noise_in;
   logic [31:0]        sq_ff, sq_in;
   logic signed [W-1:0] prod_ff, prod_in;
   logic [47:0]        acc_ff, acc_in;
   logic [23:0]        tally_ff, tally_in;
   hpmc_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rv_ff, rv_in;

   logic signed [32:0] op_a, op_b;
   logic [30:0]        v_sel;
   logic signed [31:0] s_sel;
   logic signed [W-1:0] sh12, shf, nz, vsum, vabs, dd;
   logic [30:0]        v_new;
   logic signed [31:0] s_new, f_new;
   logic [31:0]        root;
   logic               root_done;
   logic signed [33:0] pm, pt;
   logic [34:0]        psum;
   logic [30:0]        pay;
   logic [48:0]        acc_sum;

   assign v_sel = cmd.twin ? vt_ff : vm_ff;
   assign s_sel = cmd.twin ? st_ff : sm_ff;

   hpmc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.sq_go),
      .radicand (64'(v_sel) << FRAC_BITS),
      .root     (root),
      .done     (root_done)
   );

   // multiplier operand select
   always_comb begin
      case (cmd.op)
         hpmc_pkg::OP_DZ: begin
            op_a = {2'b00, cfg.root_dt};
            op_b = 33'(req_ff.normal_a);
         end
         hpmc_pkg::OP_WA: begin
            op_a = 33'(cfg.volvol_rho_sdt);
            op_b = 33'(req_ff.normal_a);
         end
         hpmc_pkg::OP_WB: begin
            op_a = {2'b00, cfg.volvol_comp_sdt};
            op_b = 33'(req_ff.normal_b);
         end
         hpmc_pkg::OP_NOISE: begin
            op_a = {1'b0, sq_ff};
            op_b = 33'(w_ff);
         end
         hpmc_pkg::OP_KAP: begin
            op_a = {2'b00, cfg.kappa_dt};
            op_b = $signed({2'b00, cfg.long_var}) - $signed({2'b00, v_sel});
         end
         hpmc_pkg::OP_D: begin
            op_a = {1'b0, sq_ff};
            op_b = 33'(dz_ff);
         end
         hpmc_pkg::OP_S: begin
            op_a = 33'(s_sel);
            op_b = 33'(f_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = W'(op_a) * W'(op_b);
   end

   // product write-back arithmetic (floored shifts)
   always_comb begin
      sh12  = prod_ff >>> 12;
      shf   = prod_ff >>> FRAC_BITS;
      nz    = cmd.twin ? -W'(noise_ff) : W'(noise_ff);
      vsum  = $signed(W'({1'b0, v_sel})) + shf + nz;
      vabs  = (vsum < 0) ? -vsum : vsum;
      v_new = (vabs > hpmc_pkg::SAT_HI) ? hpmc_pkg::SAT_HI[30:0] : vabs[30:0];
      dd    = cmd.twin ? -shf : shf;
      f_new = hpmc_pkg::sat32(W'(cfg.rate_dt) + dd);
      s_new = hpmc_pkg::sat32(W'(s_sel) + shf);
   end

   // payoff of the twins
   always_comb begin
      pm = 34'(req_ff.path_end ? sm_ff : sm_ff) - $signed({3'b000, cfg.strike_ratio});
      pt = 34'(st_ff) - $signed({3'b000, cfg.strike_ratio});
      if (pm < 0) pm = '0;
      if (pt < 0) pt = '0;
      psum    = 35'(pm[32:0]) + 35'(pt[32:0]);
      pay     = psum[31:1];
      acc_sum = 49'(acc_ff) + 49'(pay);
   end

   // state updates
   always_comb begin
      req_in   = req_ff;
      vm_in    = vm_ff;
      vt_in    = vt_ff;
      sm_in    = sm_ff;
      st_in    = st_ff;
      dz_in    = dz_ff;
      w_in     = w_ff;
      f_in     = f_ff;
      tmp_in   = tmp_ff;
      noise_in = noise_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      tally_in = tally_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff;

      if (cmd.take) begin
         req_in = req_data;
      end
      if (cmd.load) begin
         vm_in = cfg.start_var;
         vt_in = cfg.start_var;
         sm_in = ONE;
         st_in = ONE;
      end
      if (cmd.sq_wb) begin
         sq_in = root;
      end
      if (cmd.wb) begin
         case (cmd.op)
            hpmc_pkg::OP_DZ:    dz_in    = hpmc_pkg::sat32(sh12);
            hpmc_pkg::OP_WA:    tmp_in   = sh12[35:0];
            hpmc_pkg::OP_WB:    w_in     = hpmc_pkg::sat32(W'(tmp_ff) + sh12);
            hpmc_pkg::OP_NOISE: noise_in = shf[49:0];
            hpmc_pkg::OP_KAP: begin
               if (cmd.twin) vt_in = v_new;
               else          vm_in = v_new;
            end
            hpmc_pkg::OP_D:     f_in     = f_new;
            hpmc_pkg::OP_S: begin
               if (cmd.twin) st_in = s_new;
               else          sm_in = s_new;
            end
            default: ;
         endcase
      end

      // result register drains on handshake
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (cmd.pay) begin
         rsp_in.path_payoff  = pay;
         rsp_in.payoff_total = acc_sum[48] ? '1 : acc_sum[47:0];
         rsp_in.paths_done   = (&tally_ff) ? tally_ff : tally_ff + 24'd1;
         rsp_in.batch_last   = req_ff.batch_end;
         rv_in               = 1'b1;
         if (req_ff.batch_end) begin
            acc_in   = '0;
            tally_in = '0;
         end else begin
            acc_in   = rsp_in.payoff_total;
            tally_in = rsp_in.paths_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      vm_ff    <= vm_in;
      vt_ff    <= vt_in;
      sm_ff    <= sm_in;
      st_ff    <= st_in;
      dz_ff    <= dz_in;
      w_ff     <= w_in;
      f_ff     <= f_in;
      tmp_ff   <= tmp_in;
      noise_ff <= noise_in;
      sq_ff    <= sq_in;
      rsp_ff   <= rsp_in;
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (reset) begin
         acc_ff   <= '0;
         tally_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         tally_ff <= tally_in;
         rv_ff    <= rv_in;
      end
   end

   assign sts.pend     = req_ff.path_end;
   assign sts.sq_done  = root_done;
   assign sts.out_busy = rv_ff && !rsp_ready;
   assign rsp_valid    = rv_ff;
   assign rsp_data     = rsp_ff;

endmodule

// File: src/hpmc_ctrl.sv
// Controller of the Heston path stepper: walks the datapath through the
// step sequence of one time step. Depends on hpmc_pkg.
module hpmc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hpmc_pkg::sts_type sts,
   output hpmc_pkg::cmd_type cmd
);

   localparam int SW = hpmc_pkg::STEP_W;
   localparam logic [SW-1:0] LAST = SW'(hpmc_pkg::NUM_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_WB,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_PAY
   } state_type;

   state_type          state_ff, state_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               open_ff, open_in;
   hpmc_pkg::step_type cur, nxt;

   assign cur = hpmc_pkg::step_op(step_ff);
   assign nxt = hpmc_pkg::step_op(step_ff + SW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      open_in  = open_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               step_in  = '0;
               state_in = open_ff ? ST_MUL : ST_LOAD;
            end
         end
         ST_LOAD: begin
            open_in  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_WB;
         ST_SQ_GO: state_in = ST_SQ_WAIT;
         ST_WB, ST_SQ_WAIT: begin
            if (state_ff == ST_WB || sts.sq_done) begin
               if (step_ff == LAST) begin
                  state_in = sts.pend ? ST_PAY : ST_IDLE;
               end else begin
                  step_in  = step_ff + SW'(1);
                  state_in = (nxt.op == hpmc_pkg::OP_SQRT) ? ST_SQ_GO : ST_MUL;
               end
            end
         end
         ST_PAY: begin
            if (!sts.out_busy) begin
               open_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         open_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         open_ff  <= open_in;
      end
   end

   // commands
   always_comb begin
      cmd.take  = (state_ff == ST_IDLE) && req_valid;
      cmd.load  = (state_ff == ST_LOAD);
      cmd.mul   = (state_ff == ST_MUL);
      cmd.wb    = (state_ff == ST_WB);
      cmd.sq_go = (state_ff == ST_SQ_GO);
      cmd.sq_wb = (state_ff == ST_SQ_WAIT) && sts.sq_done;
      cmd.pay   = (state_ff == ST_PAY) && !sts.out_busy;
      cmd.op    = cur.op;
      cmd.twin  = cur.twin;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: src/heston_path_mc_step_core.sv
// Heston Monte Carlo path stepper, main path plus antithetic twin.
// Top level: joins hpmc_csr, hpmc_ctrl and hpmc_dp; depends on hpmc_pkg.
//
// Usage:
//  - req channel: one transaction per time step (two Q4.12 normals,
//    path_end, batch_end). req_ready is high only while the block is idle.
//  - rsp channel: one transaction per finished path (path payoff, running
//    payoff sum, path count, batch_last).
//  - csr port: APB-style, eight 32 bit registers at 4*i, no wait states;
//    write only while no time step is in flight.
// Sequence: a time step runs three multiplies, then per twin two square
// roots on the one shared bit-serial root unit and four multiplies on the
// shared multiplier; the first step of a path adds a reload of the path
// state and a path end adds a load of the result register.
// The result register parts the two channels: a stalled receiver blocks
// nothing until the next path end, where the block waits for the slot.
// Reset: registers take their reset values, the path is reloaded at the
// next step, sum and count clear and no result is pending.
module heston_path_mc_step_core #(
   parameter int FRAC_BITS = hpmc_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hpmc_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hpmc_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hpmc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [hpmc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [hpmc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   hpmc_pkg::cfg_type cfg;
   hpmc_pkg::cmd_type cmd;
   hpmc_pkg::sts_type sts;

   hpmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hpmc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/hpmc_checker.sv
// Port-level checks for heston_path_mc_step_core, attached by bind.
// Depends on hpmc_pkg.
module hpmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hpmc_pkg::rsp_type rsp_data
);

   // result stays offered while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // reset leaves no result pending
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // every result counts at least its own path
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.paths_done != '0)
      else $error("result with zero path count");

   // running sum includes this path
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.payoff_total >= 48'(rsp_data.path_payoff))
      else $error("payoff sum below path payoff");

endmodule

bind heston_path_mc_step_core hpmc_checker u_hpmc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/tb.sv
// Testbench for heston_path_mc_step_core: random and directed time steps,
// a predictor of the twin Heston paths, result checking and CSR phases.
// Depends on hpmc_pkg and the RTL of heston_path_mc_step_core.
module tb;

   localparam int  FB         = 24;
   localparam int  AW         = hpmc_pkg::CSR_AW;
   localparam int  CYCLE_MAX  = 3000000;
   localparam int  DRAIN_WAIT = 400;
   localparam longint HI32    = 64'sd2147483647;
   localparam longint LO32    = -64'sd2147483648;
   localparam longint SUM_MAX = 64'hFFFF_FFFF_FFFF;
   localparam longint CNT_MAX = 64'hFF_FFFF;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   hpmc_pkg::req_type             req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   hpmc_pkg::rsp_type             rsp_data;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [AW-1:0]                 csr_paddr = '0;
   logic [hpmc_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [hpmc_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   heston_path_mc_step_core uut (.*);

   always #5 clock = ~clock;

   // pending steps, expected path results, traffic shaping
   hpmc_pkg::req_type   step_q[$];
   hpmc_pkg::rsp_type   payoff_q[$];
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        errors = 0;
   int        cycles = 0;

   // predictor state
   hpmc_pkg::cfg_type   pcfg;
   longint    var_m, var_t, spot_m, spot_t, pay_sum, path_cnt;
   bit        in_path;

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   function automatic longint clamp32(input longint x);
      return (x > HI32) ? HI32 : ((x < LO32) ? LO32 : x);
   endfunction

   // floor division by a power of two is an arithmetic shift
   function automatic longint qmul(input longint a, input longint b, input int sh);
      return (a * b) >>> sh;
   endfunction

   // floor root of v in Q.FB, fixed 32 iterations
   function automatic longint qroot(input longint v);
      longint unsigned x, r, t;
      x = (v < 0) ? 0 : (longint'(v) << FB);
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= x) r = t;
      end
      return longint'(r);
   endfunction

   // one Euler step of one twin
   function automatic void euler_update(inout longint v, inout longint s,
                                        input longint dz, input longint w,
                                        input bit twin);
      longint n, d, f;
      n = qmul(qroot(v), w, FB);
      v = v + qmul(longint'(pcfg.kappa_dt), longint'(pcfg.long_var) - v, FB)
            + (twin ? -n : n);
      if (v < 0) v = -v;
      if (v > HI32) v = HI32;
      d = qmul(qroot(v), dz, FB);
      f = clamp32(longint'(pcfg.rate_dt) + (twin ? -d : d));
      s = clamp32(s + qmul(s, f, FB));
   endfunction

   // advance both twins; queue a result on a path end
   function automatic void predict_step(input hpmc_pkg::req_type st);
      longint a, b, dz, w, pm, pt, pay;
      hpmc_pkg::rsp_type r;
      a = longint'(st.normal_a);
      b = longint'(st.normal_b);
      if (!in_path) begin
         var_m = longint'(pcfg.start_var);
         var_t = var_m;
         spot_m = 64'sd1 << FB;
         spot_t = spot_m;
         in_path = 1'b1;
      end
      dz = clamp32(qmul(longint'(pcfg.root_dt), a, 12));
      w = clamp32(qmul(longint'(pcfg.volvol_rho_sdt), a, 12)
                + qmul(longint'(pcfg.volvol_comp_sdt), b, 12));
      euler_update(var_m, spot_m, dz, w, 1'b0);
      euler_update(var_t, spot_t, dz, w, 1'b1);
      if (!st.path_end) return;
      pm = spot_m - longint'(pcfg.strike_ratio);
      pt = spot_t - longint'(pcfg.strike_ratio);
      if (pm < 0) pm = 0;
      if (pt < 0) pt = 0;
      pay = (pm + pt) >>> 1;
      pay_sum = pay_sum + pay;
      if (pay_sum > SUM_MAX) pay_sum = SUM_MAX;
      if (path_cnt < CNT_MAX) path_cnt++;
      r.path_payoff = pay[30:0];
      r.payoff_total = pay_sum[47:0];
      r.paths_done = path_cnt[23:0];
      r.batch_last = st.batch_end;
      payoff_q.push_back(r);
      in_path = 1'b0;
      if (st.batch_end) begin
         pay_sum = 0;
         path_cnt = 0;
      end
   endfunction

   // driver: offer queued steps, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_step(req_data);
         if (!req_valid || req_ready) begin
            if (step_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= step_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compare against the oldest expectation
   always @(posedge clock) begin
      hpmc_pkg::rsp_type e;
      cycles <= cycles + 1;
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (payoff_q.size() == 0) begin
            flag_mismatch("result with nothing expected");
         end else begin
            e = payoff_q.pop_front();
            if (rsp_data.path_payoff !== e.path_payoff)
               flag_mismatch($sformatf("path_payoff %0d, expected %0d",
                                       rsp_data.path_payoff, e.path_payoff));
            if (rsp_data.payoff_total !== e.payoff_total)
               flag_mismatch($sformatf("payoff_total %0d, expected %0d",
                                       rsp_data.payoff_total, e.payoff_total));
            if (rsp_data.paths_done !== e.paths_done)
               flag_mismatch($sformatf("paths_done %0d, expected %0d",
                                       rsp_data.paths_done, e.paths_done));
            if (rsp_data.batch_last !== e.batch_last)
               flag_mismatch($sformatf("batch_last %0b, expected %0b",
                                       rsp_data.batch_last, e.batch_last));
         end
      end
      if (cycles > CYCLE_MAX) begin
         $display("simulation failed");
         $finish;
      end
   end

   // APB write: setup cycle, then access cycle
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         hpmc_pkg::REG_KAPPA_DT:        pcfg.kappa_dt = value[30:0];
         hpmc_pkg::REG_LONG_VAR:        pcfg.long_var = value[30:0];
         hpmc_pkg::REG_VOLVOL_RHO_SDT:  pcfg.volvol_rho_sdt = value;
         hpmc_pkg::REG_VOLVOL_COMP_SDT: pcfg.volvol_comp_sdt = value[30:0];
         hpmc_pkg::REG_ROOT_DT:         pcfg.root_dt = value[30:0];
         hpmc_pkg::REG_RATE_DT:         pcfg.rate_dt = value;
         hpmc_pkg::REG_STRIKE_RATIO:    pcfg.strike_ratio = value[30:0];
         default:                       pcfg.start_var = value[30:0];
      endcase
   endtask

   task automatic write_all(input logic [31:0] k, l, rho, comp, rdt, rate, strike, v0);
      write_reg(hpmc_pkg::REG_KAPPA_DT, k);
      write_reg(hpmc_pkg::REG_LONG_VAR, l);
      write_reg(hpmc_pkg::REG_VOLVOL_RHO_SDT, rho);
      write_reg(hpmc_pkg::REG_VOLVOL_COMP_SDT, comp);
      write_reg(hpmc_pkg::REG_ROOT_DT, rdt);
      write_reg(hpmc_pkg::REG_RATE_DT, rate);
      write_reg(hpmc_pkg::REG_STRIKE_RATIO, strike);
      write_reg(hpmc_pkg::REG_START_VAR, v0);
   endtask

   // block idle: steps sent, results in, last step finished
   task automatic drain();
      wait (step_q.size() == 0 && !req_valid);
      wait (payoff_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic void push_step(input int a, input int b, input bit pe, input bit be);
      hpmc_pkg::req_type st;
      st.normal_a = 16'(a);
      st.normal_b = 16'(b);
      st.path_end = pe;
      st.batch_end = be;
      step_q.push_back(st);
   endfunction

   // random paths: mostly plausible normals, some full range, some noise
   function automatic void queue_paths(input int n_steps);
      int left, len;
      left = n_steps;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
               push_step($urandom_range(65535), $urandom_range(65535),
                         i == len - 1, $urandom_range(1));
            else
               push_step($urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                         i == len - 1,
                         (i == len - 1) ? ($urandom_range(3) == 0)
                                        : ($urandom_range(19) == 0));
         end
         left -= len;
      end
   endfunction

   initial begin
      pcfg = '0;
      pcfg.strike_ratio = hpmc_pkg::STRIKE_RESET;
      var_m = 0; var_t = 0; spot_m = 64'sd1 << FB; spot_t = spot_m;
      pay_sum = 0; path_cnt = 0; in_path = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration: zero noise, spot stays one
      push_step(32767, -32768, 1'b1, 1'b0);
      push_step(0, 0, 1'b0, 1'b1);
      push_step(-32768, 32767, 1'b1, 1'b1);
      drain();

      // directed, typical market
      write_all(32'd335544, 32'd671089, -32'sd587203, 32'd599186,
                32'd1677722, 32'd8389, 32'd16777216, 32'd671089);
      push_step(32767, 32767, 1'b0, 1'b0);
      push_step(-32768, -32768, 1'b0, 1'b1);
      push_step(32767, -32768, 1'b1, 1'b0);
      push_step(-32768, 32767, 1'b1, 1'b1);
      push_step(4096, -4096, 1'b0, 1'b0);
      push_step(-4096, 4096, 1'b1, 1'b0);
      drain();

      // directed, all maxima: saturated variance and spot
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_step(32767, 32767, 1'b0, 1'b0);
      push_step(-32768, 0, 1'b1, 1'b0);
      push_step(-1, -1, 1'b1, 1'b1);
      drain();

      // directed, minima: negative rate drives spot down, zero strike
      write_all(32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
      push_step(32767, 32767, 1'b0, 1'b0);
      push_step(-32768, -32768, 1'b1, 1'b1);
      push_step(1, 1, 1'b1, 1'b0);
      drain();

      // random phases under different traffic shapes
      write_all(32'd335544, 32'd671089, -32'sd587203, 32'd599186,
                32'd1677722, 32'd8389, 32'd16777216, 32'd671089);
      queue_paths(130);
      drain();
      queue_paths(130);
      drain();

      send_idle_pct = 64;
      write_all(32'd1677722, 32'd1677722, 32'sd3000000, 32'd2000000,
                32'd5305422, -32'sd20000, 32'd14000000, 32'd3355443);
      queue_paths(260);
      drain();

      send_idle_pct = 0;
      recv_stall_pct = 64;
      write_all($urandom & 32'h00FF_FFFF, $urandom & 32'h03FF_FFFF,
                $urandom_range(16777216) - 8388608, $urandom & 32'h00FF_FFFF,
                $urandom & 32'h01FF_FFFF, $urandom_range(200000) - 100000,
                $urandom_range(20000000, 12000000), $urandom & 32'h03FF_FFFF);
      queue_paths(260);
      drain();

      send_idle_pct = 38;
      recv_stall_pct = 38;
      write_all($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
      queue_paths(100);
      drain();
      write_all(32'd335544, 32'd671089, 32'sd587203, 32'd599186,
                32'd1677722, 32'd8389, 32'd18000000, 32'd671089);
      queue_paths(160);
      drain();

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
